FILE: rtl/core/particle_sensor_frame_parser_unit_defines.svh
// ----------------------------------------------------------------------------
// Particle sensor frame parser: assertion macros
// Shared concurrent assertion wrappers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_SENSOR_FRAME_PARSER_UNIT_DEFINES_SVH
`define PARTICLE_SENSOR_FRAME_PARSER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define PSFP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("psfp assertion failed");

// Condition must never be true outside reset.
`define PSFP_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("psfp forbidden condition seen");

`else

`define PSFP_ASSERT(lbl, clk, rstn, prop)
`define PSFP_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

FILE: rtl/core/psfp_pkg.sv
// ----------------------------------------------------------------------------
// Particle sensor frame parser package
// Shared constants, codes, result type and field slot decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psfp_pkg;

  localparam int unsigned FrameBytesDef = 32;
  localparam int unsigned NumFields     = 9;
  localparam int unsigned FieldW        = 16;
  localparam int unsigned SlotW         = 4;

  localparam logic [7:0]  StartFirstRst  = 8'd66;
  localparam logic [7:0]  StartSecondRst = 8'd77;
  localparam logic [15:0] SyncLimitRst   = 16'd1000;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusBadSum  = 2'd1,
    StatusTimeout = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CfgStartFirst  = 2'd0,
    CfgStartSecond = 2'd1,
    CfgSyncLimit   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    status_e                             status;
    logic [NumFields-1:0][FieldW-1:0]    field;
  } result_t;

  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] idx;
  } slot_t;

  // Field slot completed by the low byte at a frame position.
  function automatic slot_t slot_of(logic [7:0] pos);
    slot_t s;
    s.hit = 1'b1;
    s.idx = '0;
    unique case (pos)
      8'd5:    s.idx = 4'd0;
      8'd7:    s.idx = 4'd1;
      8'd9:    s.idx = 4'd2;
      8'd17:   s.idx = 4'd3;
      8'd19:   s.idx = 4'd4;
      8'd21:   s.idx = 4'd5;
      8'd23:   s.idx = 4'd6;
      8'd25:   s.idx = 4'd7;
      8'd27:   s.idx = 4'd8;
      default: s.hit = 1'b0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/psfp_out_buf.sv
// ----------------------------------------------------------------------------
// Particle sensor frame parser: result buffer
// Output register plus skid stage, so results never block byte intake
// unless two results are already waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psfp_out_buf (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                res_valid_i,
  input  psfp_pkg::result_t  res_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output psfp_pkg::result_t  out_o
);
  import psfp_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    take;

  assign take    = out_valid_q & out_ready_i;
  assign ready_o = ~skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      // drain the skid stage into the output register
      if (take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (res_valid_i) begin
      if (!out_valid_q || take) begin
        out_d       = res_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res_i;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

FILE: rtl/core/particle_sensor_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// Particle sensor frame parser
// Hunts for the start marker in received serial bytes, collects fixed-length
// frames, checks the 16-bit checksum and emits concentrations and counts.
// ----------------------------------------------------------------------------
// One received byte is taken in every clock cycle unless the skid stage is full; each byte is handled by a
// single marker compare, a 16-bit add and a field store in the same cycle.
// A result (frame end or sync timeout) is presented on the master side from
// the cycle after the byte that caused it, or once the result ahead of it has
// been taken. The result register is backed by a one-entry skid stage, so the
// slave side only stalls while two results wait to be taken. Result tuser
// carries the status (0 ok, 1 checksum mismatch, 2 sync timeout); a timeout
// result has all data fields at zero.
// There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

`include "particle_sensor_frame_parser_unit_defines.svh"

module particle_sensor_frame_parser_unit #(
  parameter int unsigned FRAME_BYTES = psfp_pkg::FrameBytesDef
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  // configuration write port
  input  wire           cfg_we_i,
  input  wire  [1:0]    cfg_idx_i,
  input  wire  [15:0]   cfg_wdata_i,
  // received bytes
  input  wire           s_axis_tvalid,
  output logic          s_axis_tready,
  input  wire  [7:0]    s_axis_tdata,   // [7:0] rx_byte
  // results
  output logic          m_axis_tvalid,
  input  wire           m_axis_tready,
  // [15:0] pm1_conc, [31:16] pm25_conc, [47:32] pm10_conc, [63:48] count_03,
  // [79:64] count_05, [95:80] count_1, [111:96] count_25, [127:112] count_5,
  // [143:128] count_10
  output logic [143:0]  m_axis_tdata,
  output logic [1:0]    m_axis_tuser    // [1:0] status
);
  import psfp_pkg::*;

  localparam int unsigned PosW = $clog2(FRAME_BYTES);
  localparam logic [PosW-1:0] PosAfterMark = PosW'(2);
  localparam logic [PosW-1:0] PosHiTrailer = PosW'(FRAME_BYTES - 2);
  localparam logic [PosW-1:0] PosLast      = PosW'(FRAME_BYTES - 1);

  typedef enum logic [1:0] {
    ModeHunt    = 2'b01,
    ModeCollect = 2'b10
  } mode_e;

  mode_e           mode_q, mode_d;
  logic            first_q, first_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     sum_q, sum_d;
  logic [15:0]     tries_q, tries_d;
  logic [7:0]      hold_q, hold_d;
  logic [7:0]      start_first_q, start_second_q;
  logic [15:0]     limit_q;
  logic [NumFields-1:0][FieldW-1:0] store_q;
  logic [NumFields-1:0]             store_en;

  logic        acc;
  logic [7:0]  b;
  logic [15:0] tries_dec;
  slot_t       slot;
  logic        res_valid;
  result_t     res;
  logic        buf_ready;
  result_t     out_res;

  assign b    = s_axis_tdata;
  assign acc  = s_axis_tvalid & buf_ready;
  assign slot = slot_of(8'(pos_q));
  assign tries_dec = (tries_q == 16'd0) ? 16'd0 : tries_q - 16'd1;

  always_comb begin
    mode_d    = mode_q;
    first_d   = first_q;
    pos_d     = pos_q;
    sum_d     = sum_q;
    tries_d   = tries_q;
    hold_d    = hold_q;
    store_en  = '0;
    res_valid = 1'b0;
    res       = '0;
    if (acc) begin
      unique case (mode_q)
        ModeHunt: begin
          tries_d = tries_dec;
          priority if (b == start_first_q) begin
            first_d = 1'b1;
          end else if (first_q && b == start_second_q) begin
            // sync: marker bytes open the checksum
            mode_d  = ModeCollect;
            first_d = 1'b0;
            pos_d   = PosAfterMark;
            sum_d   = {8'h00, start_first_q} + {8'h00, start_second_q};
          end else begin
            first_d = 1'b0;
          end
          if (!(first_q && b != start_first_q && b == start_second_q)
              && tries_dec == 16'd0) begin
            // give up and restart the hunt
            res_valid  = 1'b1;
            res.status = StatusTimeout;
            first_d    = 1'b0;
            tries_d    = limit_q;
          end
        end
        ModeCollect: begin
          if (pos_q < PosHiTrailer) begin
            sum_d = sum_q + {8'h00, b};
            if (slot.hit) begin
              for (int k = 0; k < NumFields; k++) begin
                store_en[k] = (slot.idx == SlotW'(k));
              end
            end else begin
              hold_d = b;
            end
            pos_d = pos_q + PosW'(1);
          end else if (pos_q == PosHiTrailer) begin
            hold_d = b;
            pos_d  = pos_q + PosW'(1);
          end else begin
            res_valid  = 1'b1;
            res.status = ({hold_q, b} == sum_q) ? StatusOk : StatusBadSum;
            res.field  = store_q;
            mode_d     = ModeHunt;
            first_d    = 1'b0;
            pos_d      = '0;
            tries_d    = limit_q;
          end
        end
        default: begin
        end
      endcase
    end
    // limit write while hunting reloads the try counter
    if (cfg_we_i && cfg_idx_i == CfgSyncLimit && mode_q == ModeHunt) begin
      tries_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeHunt;
      first_q <= 1'b0;
      pos_q   <= '0;
      sum_q   <= '0;
      tries_q <= SyncLimitRst;
      hold_q  <= '0;
    end else begin
      mode_q  <= mode_d;
      first_q <= first_d;
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      tries_q <= tries_d;
      hold_q  <= hold_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_first_q  <= StartFirstRst;
      start_second_q <= StartSecondRst;
      limit_q        <= SyncLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgStartFirst:  start_first_q  <= cfg_wdata_i[7:0];
        CfgStartSecond: start_second_q <= cfg_wdata_i[7:0];
        CfgSyncLimit:   limit_q        <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumFields; k++) begin
      if (store_en[k]) begin
        store_q[k] <= {hold_q, b};
      end
    end
  end

  psfp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .ready_o     (buf_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out_res)
  );

  assign s_axis_tready = buf_ready;
  assign m_axis_tdata  = out_res.field;
  assign m_axis_tuser  = out_res.status;

  `PSFP_ASSERT_NEVER(a_hunt_pos_zero, clk_i, rst_ni, mode_q == ModeHunt && pos_q != '0)
  `PSFP_ASSERT_NEVER(a_collect_pos_range, clk_i, rst_ni,
                     mode_q == ModeCollect && (pos_q < PosAfterMark || pos_q > PosLast))
  `PSFP_ASSERT(a_frame_end_result, clk_i, rst_ni,
               (acc && mode_q == ModeCollect && pos_q == PosLast) |=> m_axis_tvalid)
  `PSFP_ASSERT_NEVER(a_hunt_no_sum_change, clk_i, rst_ni,
                     mode_q == ModeHunt && mode_d == ModeHunt && sum_d != sum_q)

endmodule

`default_nettype wire
